// File: rtl/htac_pkg.sv
// package for the holdings table with count-weighted average price
`default_nettype none

package htac_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 24;
    localparam int PRICE_BITS = 32;

    localparam int KEY_W       = 16;
    localparam int IN_CNT_W    = 24;
    localparam int IN_PRICE_W  = 32;
    localparam int STATUS_W    = 3;
    localparam int ACTION_W    = 2;

    localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SUM_W      = ((COUNT_BITS > IN_CNT_W) ? COUNT_BITS : IN_CNT_W) + 1;
    localparam int PSAT_W     = (PRICE_BITS > IN_PRICE_W) ? PRICE_BITS : IN_PRICE_W;
    localparam int DIGIT_W    = 8;
    localparam int NUM_DIGITS = (COUNT_BITS + DIGIT_W - 1) / DIGIT_W;
    localparam int DIG_BITS   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int PAD_W      = NUM_DIGITS * DIGIT_W;
    localparam int PROD_W     = PRICE_BITS + DIGIT_W;
    localparam int REM_W      = COUNT_BITS + 1;
    localparam int NUM_W      = PRICE_BITS + REM_W;
    localparam int QBIT_BITS  = $clog2(PRICE_BITS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_COUNT = 3'd1,
        ST_SHORT     = 3'd2,
        ST_FULL      = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [KEY_W-1:0]      key;
        logic [IN_CNT_W-1:0]   share_count;
        logic [IN_PRICE_W-1:0] unit_price;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [IN_CNT_W-1:0]   held_count;
        logic [IN_PRICE_W-1:0] average_price;
    } t_out_item;

    typedef struct packed {
        logic                  set_entry;
        logic                  clr_valid;
        logic                  upd_cnt;
        logic                  upd_price;
        logic [IDX_BITS-1:0]   idx;
        logic [KEY_W-1:0]      key;
        logic [COUNT_BITS-1:0] cnt;
        logic [PRICE_BITS-1:0] price;
    } t_tbl_wr;

endpackage

`default_nettype wire

// File: rtl/holdings_table_average_cost.sv
// holdings table with count-weighted average price, top level
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------
//  in      | i_in_valid  | o_in_ready  | i_in_item  (t_in_item)
//  out     | o_out_valid | i_out_ready | o_out_item (t_out_item)
//
//  an item passes through a key scan over the slots, one slot a cycle
//  a merging add then goes through the shared PRICE_BITS x 8 multiplier,
//  then a restoring divider, one quotient bit a cycle
//  reset clears all the valid bits directly, no clearing pass
//  a finished beat waits in the output register while the next item is taken
`default_nettype none

module holdings_table_average_cost
    import htac_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_state r_state, n_state;

    logic                  r_valid [ENTRIES];
    logic [KEY_W-1:0]      r_key   [ENTRIES];
    logic [COUNT_BITS-1:0] r_cnt   [ENTRIES];
    logic [PRICE_BITS-1:0] r_price [ENTRIES];

    t_action               r_act;
    logic [KEY_W-1:0]      r_key_in;
    logic [IN_CNT_W-1:0]   r_cnt_in;
    logic [PRICE_BITS-1:0] r_price_in;

    logic [IDX_BITS-1:0]   r_idx;
    logic                  r_found;
    logic [IDX_BITS-1:0]   r_slot;
    logic                  r_free_ok;
    logic [IDX_BITS-1:0]   r_free;

    logic [COUNT_BITS-1:0] r_total;
    logic [NUM_W-1:0]      r_acc;
    logic [DIG_BITS-1:0]   r_dig;
    logic                  r_phase;
    logic [QBIT_BITS-1:0]  r_qcnt;

    t_out_item             r_res, n_res;
    t_out_item             r_out;
    logic                  r_out_valid;

    t_tbl_wr               wr;

    logic [PSAT_W-1:0]     in_price_ext;
    logic [PRICE_BITS-1:0] in_price_sat;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic [PRICE_BITS-1:0] cur_price;
    logic [SUM_W-1:0]      cnt_ext;
    logic [SUM_W-1:0]      cur_ext;
    logic [SUM_W-1:0]      sum;
    logic                  cnt_big;
    logic                  sum_big;
    logic [COUNT_BITS-1:0] cnt_st;
    logic [IN_CNT_W-1:0]   rep_cnt;
    logic [IN_PRICE_W-1:0] rep_price;
    logic                  key_hit;
    logic                  out_free;

    logic [PRICE_BITS-1:0] mul_a;
    logic [PAD_W-1:0]      mul_b;
    logic [DIGIT_W-1:0]    mul_digit;
    logic [PROD_W-1:0]     mul_prod;
    logic [NUM_W-1:0]      acc_next;

    logic [REM_W:0]        div_t;
    logic [REM_W:0]        div_tot;
    logic                  div_ge;
    logic [REM_W:0]        div_rem;
    logic [PRICE_BITS-1:0] quo_next;

    assign in_price_ext = PSAT_W'(i_in_item.unit_price);
    assign in_price_sat = (in_price_ext > PSAT_W'(PRICE_MAX)) ? PRICE_MAX
                                                              : PRICE_BITS'(in_price_ext);

    assign cur_cnt   = r_cnt[r_slot];
    assign cur_price = r_price[r_slot];
    assign cnt_ext   = SUM_W'(r_cnt_in);
    assign cur_ext   = SUM_W'(cur_cnt);
    assign sum       = cur_ext + cnt_ext;
    assign cnt_big   = cnt_ext > SUM_W'(COUNT_MAX);
    assign sum_big   = sum > SUM_W'(COUNT_MAX);
    assign cnt_st    = COUNT_BITS'(r_cnt_in);
    assign rep_cnt   = r_found ? IN_CNT_W'(cur_cnt) : '0;
    assign rep_price = r_found ? IN_PRICE_W'(cur_price) : '0;
    assign key_hit   = r_valid[r_idx] && (r_key[r_idx] == r_key_in);
    assign out_free  = !r_out_valid || i_out_ready;

    // shared multiplier: old price x old count digit, then new price x new count digit
    assign mul_a     = r_phase ? r_price_in : cur_price;
    assign mul_b     = r_phase ? PAD_W'(cnt_st) : PAD_W'(cur_cnt);
    assign mul_digit = mul_b[r_dig*DIGIT_W +: DIGIT_W];
    assign mul_prod  = mul_a * mul_digit;
    assign acc_next  = r_phase ? (r_acc + NUM_W'(mul_prod))
                               : ((r_acc << DIGIT_W) + NUM_W'(mul_prod));

    // restoring divide step, remainder in the upper part of r_acc
    assign div_t    = {r_acc[NUM_W-1:PRICE_BITS], r_acc[PRICE_BITS-1]};
    assign div_tot  = (REM_W+1)'(r_total);
    assign div_ge   = div_t >= div_tot;
    assign div_rem  = div_ge ? (div_t - div_tot) : div_t;
    assign quo_next = {r_acc[PRICE_BITS-2:0], div_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        n_res             = r_res;
        wr                = '0;
        wr.idx            = r_slot;
        wr.key            = r_key_in;
        wr.cnt            = cnt_st;
        wr.price          = r_price_in;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == IDX_BITS'(ENTRIES - 1)) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state             = S_DONE;
                n_res.status        = ST_OK;
                n_res.held_count    = rep_cnt;
                n_res.average_price = rep_price;
                unique case (r_act)
                    ACT_ADD: begin
                        if (r_cnt_in == '0) begin
                            n_res.status = ST_BAD_COUNT;
                        end else if (cnt_big) begin
                            n_res.status = ST_OVERFLOW;
                        end else if (r_found) begin
                            if (sum_big) begin
                                n_res.status = ST_OVERFLOW;
                            end else begin
                                n_state = S_MUL;
                            end
                        end else if (r_free_ok) begin
                            wr.set_entry        = 1'b1;
                            wr.idx              = r_free;
                            n_res.held_count    = IN_CNT_W'(cnt_st);
                            n_res.average_price = IN_PRICE_W'(r_price_in);
                        end else begin
                            n_res.status = ST_FULL;
                        end
                    end
                    ACT_REMOVE: begin
                        if (r_cnt_in == '0) begin
                            n_res.status = ST_BAD_COUNT;
                        end else if (!r_found) begin
                            n_res.status = ST_NOT_FOUND;
                        end else if (cur_ext < cnt_ext) begin
                            n_res.status = ST_SHORT;
                        end else if (cur_ext > cnt_ext) begin
                            wr.upd_cnt       = 1'b1;
                            wr.cnt           = COUNT_BITS'(cur_ext - cnt_ext);
                            n_res.held_count = IN_CNT_W'(cur_ext - cnt_ext);
                        end else begin
                            wr.clr_valid        = 1'b1;
                            n_res.held_count    = '0;
                            n_res.average_price = '0;
                        end
                    end
                    ACT_DELETE: begin
                        if (!r_found) begin
                            n_res.status = ST_NOT_FOUND;
                        end else begin
                            wr.clr_valid        = 1'b1;
                            n_res.held_count    = '0;
                            n_res.average_price = '0;
                        end
                    end
                    ACT_QUERY: begin
                        if (!r_found) begin
                            n_res.status = ST_NOT_FOUND;
                        end
                    end
                endcase
            end
            S_MUL: begin
                if (r_phase && (r_dig == '0)) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_qcnt == '0) begin
                    n_state             = S_DONE;
                    wr.upd_cnt          = 1'b1;
                    wr.upd_price        = 1'b1;
                    wr.cnt              = r_total;
                    wr.price            = quo_next;
                    n_res.status        = ST_OK;
                    n_res.held_count    = IN_CNT_W'(r_total);
                    n_res.average_price = IN_PRICE_W'(quo_next);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (wr.set_entry) begin
            r_valid[wr.idx] <= 1'b1;
        end else if (wr.clr_valid) begin
            r_valid[wr.idx] <= 1'b0;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (wr.set_entry) begin
            r_key[wr.idx]   <= wr.key;
            r_cnt[wr.idx]   <= wr.cnt;
            r_price[wr.idx] <= wr.price;
        end else begin
            if (wr.upd_cnt) begin
                r_cnt[wr.idx] <= wr.cnt;
            end
            if (wr.upd_price) begin
                r_price[wr.idx] <= wr.price;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_act      <= t_action'(i_in_item.action);
                    r_key_in   <= i_in_item.key;
                    r_cnt_in   <= i_in_item.share_count;
                    r_price_in <= in_price_sat;
                    r_idx      <= '0;
                    r_found    <= 1'b0;
                    r_free_ok  <= 1'b0;
                end
            end
            S_SCAN: begin
                r_idx <= r_idx + 1'b1;
                if (key_hit && !r_found) begin
                    r_found <= 1'b1;
                    r_slot  <= r_idx;
                end
                if (!r_valid[r_idx] && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                    r_free    <= r_idx;
                end
            end
            S_EXEC: begin
                r_total <= COUNT_BITS'(sum);
                r_acc   <= '0;
                r_dig   <= DIG_BITS'(NUM_DIGITS - 1);
                r_phase <= 1'b0;
                r_qcnt  <= QBIT_BITS'(PRICE_BITS - 1);
            end
            S_MUL: begin
                r_acc   <= acc_next;
                r_phase <= !r_phase;
                if (r_phase) begin
                    r_dig <= r_dig - 1'b1;
                end
            end
            S_DIV: begin
                r_acc  <= {div_rem[REM_W-1:0], quo_next};
                r_qcnt <= r_qcnt - 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    // output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in work");

    a_new_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.set_entry |-> !r_valid[wr.idx])
        else $error("new entry written over a live slot");

    a_merge_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MUL) || (r_state == S_DIV)) |-> (r_found && (r_total != '0)))
        else $error("merge without a matching slot");

    a_rem_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_acc[NUM_W-1:PRICE_BITS] < REM_W'(r_total)))
        else $error("divider remainder out of range");

    a_done_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result left a held output beat");

endmodule

`default_nettype wire
